// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property check: prop is a complete property expression.
`define VDK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle check: ante at one edge implies cons at the following edge.
`define VDK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/vdk_pkg.sv =====
`default_nettype none

package vdk_pkg;

    localparam int VALUE_WIDTH_DEF = 24;
    localparam int TICK_W          = 24;
    localparam int FRAC_BITS       = 16;
    localparam int CFG_IDX_W       = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT  = 3'd4;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_TURN = 1'b1;

    // Upper limit resets to 1.0 in the fixed point format.
    localparam int UPPER_RESET     = 1 << FRAC_BITS;
    localparam int IDLE_LIMIT_RESET = 300;

endpackage

`default_nettype wire

// ===== hw/rtl/vdk_if.sv =====
`default_nettype none

interface vdk_in_if #(
    parameter int W = 24
);
    logic                valid;
    logic                ready;
    logic                op;
    logic signed [W-1:0] cur_value;
    logic signed [W-1:0] step;

    modport source (output valid, op, cur_value, step, input ready);
    modport sink   (input valid, op, cur_value, step, output ready);
endinterface

interface vdk_out_if #(
    parameter int W = 24
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] new_value;

    modport source (output valid, new_value, input ready);
    modport sink   (input valid, new_value, output ready);
endinterface

interface vdk_cfg_if #(
    parameter int IDX_W  = 3,
    parameter int DATA_W = 24
);
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  reg_index;
    logic [DATA_W-1:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vdk_cfg_regs.sv =====
`default_nettype none

module vdk_cfg_regs #(
    parameter int VALUE_WIDTH = vdk_pkg::VALUE_WIDTH_DEF,
    parameter int DATA_W      = vdk_pkg::TICK_W
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_wr,
    input  wire logic [vdk_pkg::CFG_IDX_W-1:0]     i_idx,
    input  wire logic [DATA_W-1:0]                 i_wdata,
    output logic signed [VALUE_WIDTH-1:0]          o_center,
    output logic        [VALUE_WIDTH-2:0]          o_zone,
    output logic signed [VALUE_WIDTH-1:0]          o_lower,
    output logic signed [VALUE_WIDTH-1:0]          o_upper,
    output logic        [vdk_pkg::TICK_W-1:0]      o_idle_limit
);
    import vdk_pkg::*;

    localparam int W = VALUE_WIDTH;

    logic signed [W-1:0]  r_center;
    logic        [W-2:0]  r_zone;
    logic signed [W-1:0]  r_lower;
    logic signed [W-1:0]  r_upper;
    logic [TICK_W-1:0]    r_idle_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center     <= '0;
            r_zone       <= '0;
            r_lower      <= '0;
            r_upper      <= W'(UPPER_RESET);
            r_idle_limit <= TICK_W'(IDLE_LIMIT_RESET);
        end else if (i_wr) begin
            case (i_idx)
                REG_CENTER:      r_center     <= i_wdata[W-1:0];
                REG_ZONE:        r_zone       <= i_wdata[W-2:0];
                REG_LOWER_LIMIT: r_lower      <= i_wdata[W-1:0];
                REG_UPPER_LIMIT: r_upper      <= i_wdata[W-1:0];
                REG_IDLE_LIMIT:  r_idle_limit <= i_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_center     = r_center;
    assign o_zone       = r_zone;
    assign o_lower      = r_lower;
    assign o_upper      = r_upper;
    assign o_idle_limit = r_idle_limit;

endmodule

`default_nettype wire

// ===== hw/rtl/vdk_detent.sv =====
`default_nettype none

module vdk_detent #(
    parameter int VALUE_WIDTH = vdk_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire logic                          i_op,
    input  wire logic signed [VALUE_WIDTH-1:0] i_cur,
    input  wire logic signed [VALUE_WIDTH-1:0] i_step,
    input  wire logic signed [VALUE_WIDTH-1:0] i_center,
    input  wire logic        [VALUE_WIDTH-2:0] i_zone,
    input  wire logic signed [VALUE_WIDTH-1:0] i_lower,
    input  wire logic signed [VALUE_WIDTH-1:0] i_upper,
    input  wire logic [vdk_pkg::TICK_W-1:0]    i_idle_limit,
    output logic signed [VALUE_WIDTH-1:0]      o_res
);
    import vdk_pkg::*;

    `include "assert_macros.svh"

    localparam int W = VALUE_WIDTH;

    logic signed [W-1:0]  r_held;
    logic signed [W-1:0]  n_held;
    logic [TICK_W-1:0]    r_idle;
    logic [TICK_W-1:0]    n_idle;

    logic signed [W-1:0]  held_idle;
    logic signed [W-1:0]  held_dir;
    logic signed [W-1:0]  held_sat;
    logic signed [W:0]    acc_sum;
    logic signed [W:0]    leave_x;
    logic signed [W:0]    cur_sum;
    logic signed [W-1:0]  nxt;
    logic signed [W:0]    dc;
    logic signed [W:0]    dn;
    logic [W+1:0]         zone_x;
    logic                 opp_dir;
    logic                 at_center;
    logic                 released;
    logic                 crossed;
    logic                 captured;

    // Clamp order: the lower test wins when the limits are inverted.
    function automatic logic signed [W-1:0] clamp_lim(input logic signed [W:0] x,
                                                      input logic signed [W-1:0] lo,
                                                      input logic signed [W-1:0] hi);
        logic signed [W:0] lo_x;
        logic signed [W:0] hi_x;
        logic signed [W:0] r;
        lo_x = {lo[W-1], lo};
        hi_x = {hi[W-1], hi};
        if (x < lo_x) begin
            r = lo_x;
        end else if (x > hi_x) begin
            r = hi_x;
        end else begin
            r = x;
        end
        return r[W-1:0];
    endfunction

    function automatic logic [W+1:0] abs_w1(input logic signed [W:0] x);
        logic signed [W+1:0] e;
        e = {x[W], x};
        return x[W] ? (W+2)'(-e) : e;
    endfunction

    always_comb begin
        held_idle = (r_idle > i_idle_limit) ? '0 : r_held;
        opp_dir   = (i_step != '0) && (held_idle != '0) && (i_step[W-1] != held_idle[W-1]);
        held_dir  = opp_dir ? '0 : held_idle;
        acc_sum   = {held_dir[W-1], held_dir} + {i_step[W-1], i_step};
        if (acc_sum[W] != acc_sum[W-1]) begin
            held_sat = acc_sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            held_sat = acc_sum[W-1:0];
        end
        zone_x    = {3'b000, i_zone};
        released  = abs_w1({held_sat[W-1], held_sat}) > zone_x;
        leave_x   = {i_center[W-1], i_center} + {held_sat[W-1], held_sat};

        cur_sum   = {i_cur[W-1], i_cur} + {i_step[W-1], i_step};
        nxt       = clamp_lim(cur_sum, i_lower, i_upper);
        dc        = {i_cur[W-1], i_cur} - {i_center[W-1], i_center};
        dn        = {nxt[W-1], nxt} - {i_center[W-1], i_center};
        crossed   = (dc != '0) && (dn != '0) && (dc[W] != dn[W]);
        captured  = (abs_w1(dc) > zone_x) && (abs_w1(dn) <= zone_x);
        at_center = (i_cur == i_center);

        if (at_center) begin
            if (released) begin
                o_res  = clamp_lim(leave_x, i_lower, i_upper);
                n_held = '0;
            end else begin
                o_res  = i_center;
                n_held = held_sat;
            end
        end else if (crossed || captured) begin
            o_res  = i_center;
            n_held = '0;
        end else begin
            o_res  = nxt;
            n_held = held_idle;
        end

        if (i_op == OP_TURN) begin
            n_idle = '0;
        end else begin
            n_idle = (r_idle == {TICK_W{1'b1}}) ? r_idle : r_idle + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_idle <= '0;
        end else if (i_adv) begin
            r_idle <= n_idle;
            if (i_op == OP_TURN) begin
                r_held <= n_held;
            end
        end
    end

    `VDK_ASSERT_NEXT(a_turn_clears_idle, i_clk, i_rst_n, i_adv && i_op == OP_TURN,
        r_idle == '0, "idle count not cleared by a turn")
    `VDK_ASSERT_NEXT(a_tick_keeps_accum, i_clk, i_rst_n, i_adv && i_op == OP_TICK,
        $stable(r_held), "tick changed the accumulator")
    `VDK_ASSERT_NEXT(a_pass_keeps_accum, i_clk, i_rst_n,
        i_adv && i_op == OP_TURN && !at_center && o_res != i_center && r_idle <= i_idle_limit,
        $stable(r_held), "plain move changed the accumulator")

endmodule

`default_nettype wire

// ===== hw/rtl/virtual_detent_knob.sv =====
// Virtual detent for a rotary control.
// Input channel i_in: op selects a tick (advances the idle counter, no result)
// or a turn (cur_value plus signed step, one result on o_out.new_value).
// Values are signed fixed point with 16 fraction bits.
// Config channel i_cfg: reg_index 0..4 selects center, zone, lower_limit,
// upper_limit, idle_limit; i_cfg.ready is always high. Write only while idle.
// A turn passes from the input register through the detent logic into the
// output register. Throughput: one item per cycle unless a turn stalls on
// o_out; the detent logic and its state update sit in a single stage between
// the input and output registers.
// When o_out stalls, a turn waits in the input register and i_in.ready
// drops; ticks still pass while the output register holds a result.
// Reset (i_rst_n low, synchronous) clears the accumulator and idle counter,
// empties both registers and loads the register reset values.
`default_nettype none

module virtual_detent_knob #(
    parameter int VALUE_WIDTH = vdk_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vdk_in_if.sink    i_in,
    vdk_out_if.source o_out,
    vdk_cfg_if.sink   i_cfg
);
    import vdk_pkg::*;

    `include "assert_macros.svh"

    localparam int W      = VALUE_WIDTH;
    localparam int DATA_W = (W > TICK_W) ? W : TICK_W;

    logic                r_s1_valid;
    logic                r_s1_op;
    logic signed [W-1:0] r_s1_cur;
    logic signed [W-1:0] r_s1_step;
    logic                r_out_valid;
    logic                n_out_valid;
    logic signed [W-1:0] r_out_value;

    logic                s1_adv;
    logic                in_acc;
    logic signed [W-1:0] res;

    logic signed [W-1:0] cfg_center;
    logic        [W-2:0] cfg_zone;
    logic signed [W-1:0] cfg_lower;
    logic signed [W-1:0] cfg_upper;
    logic [TICK_W-1:0]   cfg_idle_limit;

    assign i_cfg.ready = 1'b1;

    vdk_cfg_regs #(
        .VALUE_WIDTH (W),
        .DATA_W      (DATA_W)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (i_cfg.valid),
        .i_idx        (i_cfg.reg_index),
        .i_wdata      (i_cfg.wdata[DATA_W-1:0]),
        .o_center     (cfg_center),
        .o_zone       (cfg_zone),
        .o_lower      (cfg_lower),
        .o_upper      (cfg_upper),
        .o_idle_limit (cfg_idle_limit)
    );

    // A tick never needs the output register, so it never waits.
    assign s1_adv     = r_s1_valid && (r_s1_op == OP_TICK || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    vdk_detent #(
        .VALUE_WIDTH (W)
    ) u_detent (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (s1_adv),
        .i_op         (r_s1_op),
        .i_cur        (r_s1_cur),
        .i_step       (r_s1_step),
        .i_center     (cfg_center),
        .i_zone       (cfg_zone),
        .i_lower      (cfg_lower),
        .i_upper      (cfg_upper),
        .i_idle_limit (cfg_idle_limit),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op   <= i_in.op;
            r_s1_cur  <= i_in.cur_value;
            r_s1_step <= i_in.step;
        end
    end

    always_comb begin
        if (s1_adv && r_s1_op == OP_TURN) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_op == OP_TURN) begin
            r_out_value <= res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.new_value = r_out_value;

    `VDK_ASSERT(a_tick_flows, i_clk, i_rst_n,
        (r_s1_valid && r_s1_op == OP_TICK) |-> i_in.ready, "tick stalled the input")
    `VDK_ASSERT_NEXT(a_turn_held, i_clk, i_rst_n,
        r_s1_valid && r_s1_op == OP_TURN && r_out_valid && !o_out.ready,
        r_s1_valid && r_s1_op == OP_TURN, "stalled turn lost from input register")
    `VDK_ASSERT_NEXT(a_turn_result, i_clk, i_rst_n, s1_adv && r_s1_op == OP_TURN,
        r_out_valid, "turn produced no result")

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import vdk_pkg::*;

    localparam int W = VALUE_WIDTH_DEF;
    localparam longint VMAX = (longint'(1) << (W - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_SETTINGS = 6;
    localparam int ITEMS_PER_SETTING = 225;

    typedef logic signed [W-1:0] value_t;

    // Detent predictor plus the queue of values still owed by the block.
    class detent_scoreboard;
        value_t            center_pos;
        logic [W-2:0]      zone_radius;
        value_t            lower_lim;
        value_t            upper_lim;
        logic [TICK_W-1:0] idle_lim;
        value_t            accum;
        logic [TICK_W-1:0] idle_count;
        value_t            pending_values[$];
        int                n_turns;
        int                n_ticks;
        int                n_checked;
        int                n_mismatches;
        int                n_settings;

        function new();
            center_pos   = '0;
            zone_radius  = '0;
            lower_lim    = '0;
            upper_lim    = value_t'(UPPER_RESET);
            idle_lim     = TICK_W'(IDLE_LIMIT_RESET);
            accum        = '0;
            idle_count   = '0;
            n_turns      = 0;
            n_ticks      = 0;
            n_checked    = 0;
            n_mismatches = 0;
            n_settings   = 0;
        endfunction

        function longint clamp_to_limits(longint x);
            longint lo;
            longint hi;
            lo = lower_lim;
            hi = upper_lim;
            // low bound is tested first, so it wins when the limits are inverted
            if (x < lo) return lo;
            if (x > hi) return hi;
            return x;
        endfunction

        function longint magnitude(longint x);
            return (x < 0) ? -x : x;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [W-1:0] data);
            case (idx)
                REG_CENTER:      center_pos  = value_t'(data);
                REG_ZONE:        zone_radius = data[W-2:0];
                REG_LOWER_LIMIT: lower_lim   = value_t'(data);
                REG_UPPER_LIMIT: upper_lim   = value_t'(data);
                REG_IDLE_LIMIT:  idle_lim    = data[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function void accept_item(logic op, value_t cur, value_t stp);
            longint cur_l;
            longint stp_l;
            longint ctr;
            longint zn;
            longint acc;
            longint nxt;
            longint dc;
            longint dn;
            longint res;
            if (op == OP_TICK) begin
                n_ticks++;
                if (idle_count != {TICK_W{1'b1}}) idle_count++;
                return;
            end
            n_turns++;
            cur_l = cur;
            stp_l = stp;
            ctr   = center_pos;
            zn    = zone_radius;
            if (idle_count > idle_lim) accum = '0;
            idle_count = '0;
            acc = accum;
            if (cur_l == ctr) begin
                if ((stp_l > 0 && acc < 0) || (stp_l < 0 && acc > 0)) acc = 0;
                acc = acc + stp_l;
                if (acc > VMAX) acc = VMAX;
                if (acc < VMIN) acc = VMIN;
                if (magnitude(acc) > zn) begin
                    res = clamp_to_limits(ctr + acc);
                    acc = 0;
                end else begin
                    res = ctr;
                end
            end else begin
                nxt = clamp_to_limits(cur_l + stp_l);
                dc  = cur_l - ctr;
                dn  = nxt - ctr;
                if ((dc > 0 && dn < 0) || (dc < 0 && dn > 0)) begin
                    acc = 0;
                    res = ctr;
                end else if (magnitude(dc) > zn && magnitude(dn) <= zn) begin
                    acc = 0;
                    res = ctr;
                end else begin
                    res = nxt;
                end
            end
            accum = value_t'(acc);
            pending_values.push_back(value_t'(res));
        endfunction

        function void check_value(value_t actual);
            value_t expected;
            n_checked++;
            if (pending_values.size() == 0) begin
                n_mismatches++;
                $error("new_value: unexpected result %0d with nothing pending", actual);
                return;
            end
            expected = pending_values.pop_front();
            if (actual !== expected) begin
                n_mismatches++;
                $error("new_value mismatch: expected %0d, actual %0d", expected, actual);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    vdk_in_if  #(.W(W)) in_bus ();
    vdk_out_if #(.W(W)) out_bus ();
    vdk_cfg_if #(.IDX_W(CFG_IDX_W), .DATA_W(W)) cfg_bus ();

    virtual_detent_knob #(.VALUE_WIDTH(W)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    detent_scoreboard sb = new();

    int cycle_count = 0;
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;
    bit held_off    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic value_t sat_value(longint x);
        if (x > VMAX) return value_t'(VMAX);
        if (x < VMIN) return value_t'(VMIN);
        return value_t'(x);
    endfunction

    function automatic value_t rand_full();
        return value_t'($urandom);
    endfunction

    // Result side: random stalls, steady stretches, and one long hold-off.
    initial begin
        int gap;
        out_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!held_off && sb.n_checked >= 400) begin
                held_off = 1'b1;
                @(negedge i_clk);
                out_bus.ready = 1'b0;
                repeat (500) @(negedge i_clk);
            end
            if ($urandom_range(0, 31) == 0) recv_steady = ~recv_steady;
            gap = recv_steady ? 0 : $urandom_range(0, 16);
            repeat (gap) begin
                @(negedge i_clk);
                out_bus.ready = 1'b0;
            end
            @(negedge i_clk);
            out_bus.ready = 1'b1;
            do @(posedge i_clk); while (!out_bus.valid);
            sb.check_value(out_bus.new_value);
        end
    end

    task automatic send_item(logic op, value_t cur, value_t stp);
        int gap;
        if ($urandom_range(0, 31) == 0) send_steady = ~send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 16);
        repeat (gap) begin
            @(negedge i_clk);
            in_bus.valid = 1'b0;
        end
        @(negedge i_clk);
        in_bus.valid     = 1'b1;
        in_bus.op        = op;
        in_bus.cur_value = cur;
        in_bus.step      = stp;
        do @(posedge i_clk); while (!in_bus.ready);
        sb.accept_item(op, cur, stp);
    endtask

    task automatic turn(longint cur, longint stp);
        send_item(OP_TURN, value_t'(cur), value_t'(stp));
    endtask

    task automatic tick();
        send_item(OP_TICK, rand_full(), rand_full());
    endtask

    // Drain all pending results; ticks leave no trace, so wait out the pipeline.
    task automatic settle();
        @(negedge i_clk);
        in_bus.valid = 1'b0;
        while (sb.pending_values.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, longint data);
        @(negedge i_clk);
        cfg_bus.valid     = 1'b1;
        cfg_bus.reg_index = idx;
        cfg_bus.wdata     = W'(data);
        do @(posedge i_clk); while (!cfg_bus.ready);
        sb.set_register(idx, W'(data));
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic load_settings(longint ctr, longint zn, longint lo, longint hi,
                                 longint idle);
        settle();
        cfg_write(REG_CENTER, ctr);
        cfg_write(REG_ZONE, zn);
        cfg_write(REG_LOWER_LIMIT, lo);
        cfg_write(REG_UPPER_LIMIT, hi);
        cfg_write(REG_IDLE_LIMIT, idle);
        sb.n_settings++;
    endtask

    task automatic random_settings();
        longint ctr;
        longint zn;
        longint lo;
        longint hi;
        longint idle;
        longint span;
        case ($urandom_range(0, 7))
            0:       ctr = 0;
            1:       ctr = VMAX;
            2:       ctr = VMIN;
            default: ctr = longint'($urandom_range(0, 32'h400000)) - 32'h200000;
        endcase
        case ($urandom_range(0, 7))
            6:       zn = 0;
            7:       zn = $urandom_range(0, 32'h7FFFFF);
            default: zn = $urandom_range(0, 32'h20000);
        endcase
        // top bit of the zone write lies outside the register
        zn = zn | (longint'($urandom_range(0, 1)) << (W - 1));
        span = $urandom_range(32'h8000, 32'h300000);
        case ($urandom_range(0, 7))
            6: begin
                lo = VMIN;
                hi = VMAX;
            end
            7: begin
                lo = sat_value(ctr + span);
                hi = sat_value(ctr - span);
            end
            default: begin
                lo = sat_value(ctr - span);
                hi = sat_value(ctr + $urandom_range(32'h8000, 32'h300000));
            end
        endcase
        case ($urandom_range(0, 7))
            6:       idle = 32'hFFFFFF;
            7:       idle = $urandom_range(0, 32'hFFFFFF);
            default: idle = $urandom_range(0, 24);
        endcase
        load_settings(ctr, zn, lo, hi, idle);
    endtask

    function automatic value_t pick_value();
        longint ctr;
        longint zn;
        longint lo;
        longint hi;
        ctr = sb.center_pos;
        zn  = sb.zone_radius;
        lo  = sb.lower_lim;
        hi  = sb.upper_lim;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return value_t'(ctr);
            4, 5: begin
                if (zn > 32'h100000) zn = 32'h100000;
                return sat_value(ctr + longint'($urandom_range(0, 4 * zn + 2)) - 2 * zn - 1);
            end
            6, 7: begin
                if (lo <= hi) return value_t'(lo + $urandom_range(0, hi - lo));
                return value_t'(hi + $urandom_range(0, lo - hi));
            end
            default: return rand_full();
        endcase
    endfunction

    function automatic value_t pick_step();
        longint m;
        m = longint'(sb.zone_radius) + 32'h1000;
        if (m > 32'h400000) m = 32'h400000;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return sat_value(longint'($urandom_range(0, 2 * m)) - m);
            5, 6:          return sat_value(longint'($urandom_range(0, 32'h80000)) - 32'h40000);
            7: begin
                case ($urandom_range(0, 4))
                    0:       return value_t'(VMAX);
                    1:       return value_t'(VMIN);
                    2:       return value_t'(1);
                    3:       return value_t'(-1);
                    default: return '0;
                endcase
            end
            default: return rand_full();
        endcase
    endfunction

    task automatic random_items(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(0, 99)) inside
                [0:3]: begin
                    if (sb.idle_lim < 64) begin
                        // run past the idle limit so the accumulator gets dropped
                        burst = int'(sb.idle_lim) + $urandom_range(1, 3);
                        repeat (burst) tick();
                        sent += burst;
                    end else begin
                        tick();
                        sent++;
                    end
                end
                [4:17]: begin
                    tick();
                    sent++;
                end
                default: begin
                    send_item(OP_TURN, pick_value(), pick_step());
                    sent++;
                end
            endcase
        end
    endtask

    initial begin
        in_bus.valid      = 1'b0;
        in_bus.op         = OP_TICK;
        in_bus.cur_value  = '0;
        in_bus.step       = '0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.reg_index = REG_CENTER;
        cfg_bus.wdata     = '0;
        i_rst_n           = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values: turn just past the upper limit
        turn(32'h8000, 32'h10000);

        // zone 0.5, limits +-4.0, short idle limit
        load_settings(0, 32'h8000, -32'h40000, 32'h40000, 3);
        cfg_write(REG_SPARE, 32'h123456);
        turn(0, 32'h4000);
        turn(0, 32'h6000);
        turn(0, 32'h4000);
        turn(0, -32'h2000);
        repeat (4) tick();
        turn(0, -32'h7000);
        turn(32'h20000, -32'h30000);
        turn(32'h20000, -32'h19000);
        turn(32'h20000, VMAX);
        turn(-32'h20000, VMIN);
        turn(VMAX, VMAX);
        turn(32'h4000, 32'h100);
        turn(0, VMAX);

        // widest zone at the lowest center: accumulator saturates both ways
        load_settings(VMIN, 32'h7FFFFF, VMIN, VMAX, 0);
        turn(VMIN, VMAX);
        turn(VMIN, VMAX);
        turn(VMIN, -1);
        turn(VMIN, VMIN);

        // center at the top, no zone, idle clear disabled
        load_settings(VMAX, 0, VMIN, VMAX, 32'hFFFFFF);
        turn(VMAX, 1);
        tick();
        turn(VMAX, -1);

        // inverted limits
        load_settings(0, 32'h1000, 32'h10000, -32'h10000, 5);
        turn(32'h5000, 0);
        turn(32'h20000, 0);
        turn(-32'h20000, 0);

        for (int p = 0; p < RANDOM_SETTINGS; p++) begin
            random_settings();
            random_items(ITEMS_PER_SETTING);
        end

        settle();
        repeat (8) @(posedge i_clk);
        $display("covered %0d turns and %0d ticks under %0d register settings",
                 sb.n_turns, sb.n_ticks, sb.n_settings + 1);
        $display("checked %0d results, %0d mismatches", sb.n_checked, sb.n_mismatches);
        if (sb.n_mismatches == 0 && sb.pending_values.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/vdk_pkg.sv
hw/rtl/vdk_if.sv
hw/rtl/vdk_cfg_regs.sv
hw/rtl/vdk_detent.sv
hw/rtl/virtual_detent_knob.sv
verif/testbench.sv
